### rtl/tyae_pkg.sv
// Package for the tilt and yaw attitude estimator.
// Holds the sequencer state type, register indexes and the CORDIC angle table.
// No dependencies.
`timescale 1ns / 1ps

package tyae_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_LOAD,
		ST_DIV,
		ST_DIV_STORE,
		ST_INIT,
		ST_ITER,
		ST_MUL_HI,
		ST_MUL_LO,
		ST_YAW_T,
		ST_YAW_P,
		ST_YAW_ACC,
		ST_DONE
	} state_t;

	localparam logic [1:0] REG_GRAVITY   = 2'd0;
	localparam logic [1:0] REG_GYRO_GAIN = 2'd1;

	localparam int ANGLE_W = 26;
	localparam logic signed [ANGLE_W-1:0] DEG180 = 26'sd11796480;
	localparam logic [15:0] INV_GAIN = 16'd39797;

	// atan(2^-i) in units of 2^-16 degree, rounded to nearest.
	function automatic logic signed [ANGLE_W-1:0] atan_lut(input logic [4:0] i);
		logic signed [ANGLE_W-1:0] r;
		begin
			case (i)
				5'd0:    r = 26'sd2949120;
				5'd1:    r = 26'sd1740967;
				5'd2:    r = 26'sd919879;
				5'd3:    r = 26'sd466945;
				5'd4:    r = 26'sd234379;
				5'd5:    r = 26'sd117304;
				5'd6:    r = 26'sd58666;
				5'd7:    r = 26'sd29335;
				5'd8:    r = 26'sd14668;
				5'd9:    r = 26'sd7334;
				5'd10:   r = 26'sd3667;
				5'd11:   r = 26'sd1833;
				5'd12:   r = 26'sd917;
				5'd13:   r = 26'sd458;
				5'd14:   r = 26'sd229;
				5'd15:   r = 26'sd115;
				5'd16:   r = 26'sd57;
				5'd17:   r = 26'sd29;
				5'd18:   r = 26'sd14;
				5'd19:   r = 26'sd7;
				5'd20:   r = 26'sd4;
				5'd21:   r = 26'sd2;
				5'd22:   r = 26'sd1;
				default: r = 26'sd0;
			endcase
			return r;
		end
	endfunction

endpackage

### rtl/tyae_in_if.sv
// Input channel of the attitude estimator: valid, ready and one sensor item.
// No dependencies.
`timescale 1ns / 1ps

interface tyae_in_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [15:0] gyro_z;
	logic [15:0]        elapsed_ms;

	modport source(output valid, op, accel_x, accel_y, accel_z, gyro_z, elapsed_ms,
		input ready);
	modport sink(input valid, op, accel_x, accel_y, accel_z, gyro_z, elapsed_ms,
		output ready);
endinterface

### rtl/tyae_out_if.sv
// Output channel of the attitude estimator: valid, ready and one attitude result.
// No dependencies.
`timescale 1ns / 1ps

interface tyae_out_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] roll_angle;
	logic signed [15:0] pitch_angle;
	logic signed [16:0] yaw_angle;

	modport source(output valid, roll_angle, pitch_angle, yaw_angle, input ready);
	modport sink(input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

### rtl/tilt_and_yaw_attitude_estimator.sv
// Tilt and yaw attitude estimator top level.
// Depends on tyae_pkg, tyae_in_if and tyae_out_if.
//
// A calibration item that does not complete a calibration block is taken in the idle
// state without leaving it. The item that completes a block then runs the four rounded
// averages one after another through a shared reciprocal multiply by the constant block
// length, each through a load, a multiply and a store state. An attitude item passes
// through the single shared CORDIC stage that first computes roll and then pitch, with
// a split multiply for the gain removal between the two, and then through the YAW_T,
// YAW_P and YAW_ACC states for the yaw update. The input is not ready while an item is
// at work; a finished result sits in the output register until it is taken.
`timescale 1ns / 1ps

module tilt_and_yaw_attitude_estimator #(
	parameter int CAL_SAMPLES  = 100,
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_idx,
	input  logic [19:0] cfg_wdata,
	tyae_in_if.sink     in_ch,
	tyae_out_if.source  out_ch
);

	localparam int AW = tyae_pkg::ANGLE_W;
	localparam int IW = $clog2(CORDIC_STEPS);
	localparam logic [8:0]  NDIV = 9'(CAL_SAMPLES);
	localparam logic [23:0] HALF = 24'(CAL_SAMPLES / 2);
	localparam int DIV_SH = 24 + $clog2(CAL_SAMPLES);
	localparam logic [25:0] RECIP = 26'(((64'd1 << DIV_SH) + 64'(CAL_SAMPLES - 1)) /
		64'(CAL_SAMPLES));

	tyae_pkg::state_t state_q, state_d;

	logic [14:0] gravity_q;
	logic [19:0] gain_q;

	logic signed [23:0] sum_x_q, sum_y_q, sum_z_q, sum_g_q;
	logic [8:0]         cal_cnt_q;
	logic signed [16:0] off_x_q, off_y_q, off_z_q;
	logic signed [15:0] off_g_q;
	logic signed [24:0] yaw_q;

	logic [1:0]  div_idx_q;
	logic [23:0] dvd_q;
	logic        neg_q;

	logic signed [17:0] dx_q;
	logic signed [16:0] dg_q;
	logic [15:0]        ms_q;

	logic signed [35:0]   cx_q, cy_q;
	logic signed [AW-1:0] cz_q;
	logic [IW-1:0]        it_q;
	logic                 zero_q;
	logic                 pass_q;
	logic [35:0]          mag_q;
	logic [35:0]          hiprod_q;
	logic signed [33:0]   t_q;
	logic signed [54:0]   p_q;
	logic signed [16:0]   roll_q;
	logic signed [15:0]   pitch_q;

	logic               out_valid_q;
	logic signed [16:0] out_roll_q;
	logic signed [15:0] out_pitch_q;
	logic signed [16:0] out_yaw_q;

	logic accept, out_free, last_it;

	assign accept   = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign last_it  = (it_q == IW'(CORDIC_STEPS - 1));

	assign in_ch.ready        = (state_q == tyae_pkg::ST_IDLE);
	assign out_ch.valid       = out_valid_q;
	assign out_ch.roll_angle  = out_roll_q;
	assign out_ch.pitch_angle = out_pitch_q;
	assign out_ch.yaw_angle   = out_yaw_q;

	function automatic logic signed [17:0] round8(input logic signed [AW-1:0] a);
		logic signed [AW-1:0] s;
		begin
			s = (a + AW'(128)) >>> 8;
			return s[17:0];
		end
	endfunction

	function automatic logic signed [16:0] roll_out(input logic signed [AW-1:0] a);
		logic signed [17:0] r;
		begin
			r = round8(a);
			if (r > 18'sd46080) r = 18'sd46080;
			if (r < -18'sd46080) r = -18'sd46080;
			return r[16:0];
		end
	endfunction

	function automatic logic signed [15:0] pitch_out(input logic signed [AW-1:0] a);
		logic signed [17:0] r;
		begin
			r = round8(a);
			if (r > 18'sd23040) r = 18'sd23040;
			if (r < -18'sd23040) r = -18'sd23040;
			return r[15:0];
		end
	endfunction

	// Combinational helpers for the shared units.
	logic signed [35:0]   xs, ys;
	logic signed [AW-1:0] atan_v;
	logic signed [AW-1:0] cz_nx;
	logic [49:0]          qprod;
	logic signed [23:0]   div_sel;
	logic [23:0]          div_mag;
	logic signed [17:0]   avg;
	logic [31:0]          loprod;
	logic signed [54:0]   step, ysum, ywrap;

	always_comb begin
		xs     = cx_q >>> it_q;
		ys     = cy_q >>> it_q;
		atan_v = tyae_pkg::atan_lut(5'(it_q));
		cz_nx  = (cy_q >= 0) ? cz_q + atan_v : cz_q - atan_v;
		qprod  = dvd_q * RECIP;
		case (div_idx_q)
			2'd0:    div_sel = sum_x_q;
			2'd1:    div_sel = sum_y_q;
			2'd2:    div_sel = sum_z_q;
			default: div_sel = sum_g_q;
		endcase
		div_mag = div_sel[23] ? 24'(-div_sel) : 24'(div_sel);
		avg     = neg_q ? -$signed({1'b0, dvd_q[16:0]}) : $signed({1'b0, dvd_q[16:0]});
		loprod  = mag_q[15:0] * tyae_pkg::INV_GAIN;
		step    = (p_q + 55'sd32768) >>> 16;
		ysum    = 55'(yaw_q) + step;
		ywrap   = ysum;
		if (ysum > 55'(tyae_pkg::DEG180)) ywrap = ysum - 55'sd23592960;
		else if (ysum < -55'(tyae_pkg::DEG180)) ywrap = ysum + 55'sd23592960;
		if (ywrap > 55'(tyae_pkg::DEG180)) ywrap = 55'(tyae_pkg::DEG180);
		if (ywrap < -55'(tyae_pkg::DEG180)) ywrap = -55'(tyae_pkg::DEG180);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tyae_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tyae_pkg::ST_IDLE: begin
				if (accept) begin
					if (in_ch.op) state_d = tyae_pkg::ST_INIT;
					else if (cal_cnt_q + 9'd1 >= NDIV) state_d = tyae_pkg::ST_DIV_LOAD;
				end
			end
			tyae_pkg::ST_DIV_LOAD: state_d = tyae_pkg::ST_DIV;
			tyae_pkg::ST_DIV:      state_d = tyae_pkg::ST_DIV_STORE;
			tyae_pkg::ST_DIV_STORE: begin
				state_d = (div_idx_q == 2'd3) ? tyae_pkg::ST_IDLE : tyae_pkg::ST_DIV_LOAD;
			end
			tyae_pkg::ST_INIT: state_d = tyae_pkg::ST_ITER;
			tyae_pkg::ST_ITER: begin
				if (last_it) state_d = pass_q ? tyae_pkg::ST_YAW_T : tyae_pkg::ST_MUL_HI;
			end
			tyae_pkg::ST_MUL_HI:  state_d = tyae_pkg::ST_MUL_LO;
			tyae_pkg::ST_MUL_LO:  state_d = tyae_pkg::ST_INIT;
			tyae_pkg::ST_YAW_T:   state_d = tyae_pkg::ST_YAW_P;
			tyae_pkg::ST_YAW_P:   state_d = tyae_pkg::ST_YAW_ACC;
			tyae_pkg::ST_YAW_ACC: state_d = tyae_pkg::ST_DONE;
			tyae_pkg::ST_DONE: begin
				if (out_free) state_d = tyae_pkg::ST_IDLE;
			end
			default: state_d = tyae_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q   <= 15'd4096;
			gain_q      <= 20'd65572;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			sum_z_q     <= '0;
			sum_g_q     <= '0;
			cal_cnt_q   <= '0;
			off_x_q     <= '0;
			off_y_q     <= '0;
			off_z_q     <= '0;
			off_g_q     <= '0;
			yaw_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				if (cfg_idx == tyae_pkg::REG_GRAVITY) gravity_q <= cfg_wdata[14:0];
				else if (cfg_idx == tyae_pkg::REG_GYRO_GAIN) gain_q <= cfg_wdata;
			end
			if (state_q == tyae_pkg::ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				tyae_pkg::ST_IDLE: begin
					if (accept && !in_ch.op) begin
						sum_x_q   <= sum_x_q + 24'(in_ch.accel_x);
						sum_y_q   <= sum_y_q + 24'(in_ch.accel_y);
						sum_z_q   <= sum_z_q + 24'(in_ch.accel_z);
						sum_g_q   <= sum_g_q + 24'(in_ch.gyro_z);
						cal_cnt_q <= cal_cnt_q + 9'd1;
					end
				end
				tyae_pkg::ST_DIV_STORE: begin
					case (div_idx_q)
						2'd0:    off_x_q <= avg[16:0];
						2'd1:    off_y_q <= avg[16:0];
						2'd2:    off_z_q <= 17'(avg - $signed({3'b000, gravity_q}));
						default: off_g_q <= avg[15:0];
					endcase
					if (div_idx_q == 2'd3) begin
						sum_x_q   <= '0;
						sum_y_q   <= '0;
						sum_z_q   <= '0;
						sum_g_q   <= '0;
						cal_cnt_q <= '0;
					end
				end
				tyae_pkg::ST_YAW_ACC: yaw_q <= ywrap[24:0];
				default: ;
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		case (state_q)
			tyae_pkg::ST_IDLE: begin
				div_idx_q <= '0;
				pass_q    <= 1'b0;
				dx_q      <= 18'(in_ch.accel_x) - 18'(off_x_q);
				dg_q      <= 17'(in_ch.gyro_z) - 17'(off_g_q);
				ms_q      <= in_ch.elapsed_ms;
				cx_q      <= 36'(18'(in_ch.accel_z) - 18'(off_z_q)) <<< 14;
				cy_q      <= 36'(18'(in_ch.accel_y) - 18'(off_y_q)) <<< 14;
			end
			tyae_pkg::ST_DIV_LOAD: begin
				neg_q <= div_sel[23];
				dvd_q <= div_mag + HALF;
			end
			tyae_pkg::ST_DIV: dvd_q <= 24'(qprod >> DIV_SH);
			tyae_pkg::ST_DIV_STORE: div_idx_q <= div_idx_q + 2'd1;
			tyae_pkg::ST_INIT: begin
				zero_q <= (cx_q == '0) && (cy_q == '0);
				it_q   <= '0;
				if (cx_q < 0) begin
					cx_q <= -cx_q;
					cy_q <= -cy_q;
					cz_q <= (cy_q >= 0) ? tyae_pkg::DEG180 : -tyae_pkg::DEG180;
				end else begin
					cz_q <= '0;
				end
			end
			tyae_pkg::ST_ITER: begin
				if (cy_q >= 0) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
				end
				cz_q <= cz_nx;
				it_q <= it_q + IW'(1);
				if (last_it) begin
					if (pass_q) begin
						pitch_q <= zero_q ? 16'sd0 : pitch_out(cz_nx);
					end else begin
						roll_q <= zero_q ? 17'sd0 : roll_out(cz_nx);
						mag_q  <= zero_q ? 36'd0 : 36'(cy_q >= 0 ? cx_q + ys : cx_q - ys);
					end
				end
			end
			tyae_pkg::ST_MUL_HI: hiprod_q <= mag_q[35:16] * tyae_pkg::INV_GAIN;
			tyae_pkg::ST_MUL_LO: begin
				cx_q   <= $signed(hiprod_q + 36'(loprod[31:16]));
				cy_q   <= -(36'(dx_q) <<< 14);
				pass_q <= 1'b1;
			end
			tyae_pkg::ST_YAW_T: t_q <= 34'(dg_q * $signed({1'b0, ms_q}));
			tyae_pkg::ST_YAW_P: p_q <= 55'(t_q * $signed({1'b0, gain_q}));
			tyae_pkg::ST_DONE: begin
				if (out_free) begin
					out_roll_q  <= roll_q;
					out_pitch_q <= pitch_q;
					out_yaw_q   <= 17'((yaw_q + 25'sd128) >>> 8);
				end
			end
			default: ;
		endcase
	end

endmodule

### tb/tilt_and_yaw_attitude_estimator_tb.sv
// Testbench for the tilt and yaw attitude estimator: directed and random sensor
// items, an item-level predictor of roll, pitch and yaw, and an in-order result check.
// Depends on tyae_pkg, tyae_in_if, tyae_out_if and the estimator top level.
`timescale 1ns / 1ps

module tilt_and_yaw_attitude_estimator_tb;

	localparam int CAL_N = 100;
	localparam int STEPS = 16;
	localparam longint HALF_TURN = 64'sd11796480;
	localparam longint FULL_TURN = 64'sd23592960;
	localparam int DRAIN_CYCLES = 160;

	typedef struct {
		logic               op;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic signed [15:0] gz;
		logic [15:0]        ms;
	} sensor_t;

	typedef struct {
		logic signed [16:0] roll;
		logic signed [15:0] pitch;
		logic signed [16:0] yaw;
	} attitude_t;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic [1:0]  cfg_idx;
	logic [19:0] cfg_wdata;

	tyae_in_if  in_ch();
	tyae_out_if out_ch();

	tilt_and_yaw_attitude_estimator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	sensor_t    sensor_q[$];
	attitude_t  attitude_q[$];
	sensor_t    drv_item;
	idle_mode_t idle_mode;
	bit         in_taken;
	int         hold_req;
	int         hold_cnt;
	int         mismatches;
	int         items_in;
	int         results_out;
	int         cal_blocks;

	// Predictor state.
	longint gravity_reg, gain_reg;
	longint sum_x, sum_y, sum_z, sum_g;
	int     cal_cnt;
	longint off_x, off_y, off_z, off_g;
	longint yaw_q16;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic longint wrap_bits(longint v, int w);
		longint m;
		m = (64'sd1 <<< w) - 1;
		v = v & m;
		if (v >= (64'sd1 <<< (w - 1)))
			v = v - (64'sd1 <<< w);
		return v;
	endfunction

	function automatic longint round_mean(longint s);
		if (s < 0)
			return -((-s + CAL_N / 2) / CAL_N);
		return (s + CAL_N / 2) / CAL_N;
	endfunction

	function automatic longint vector_angle(longint x, longint y, output longint mag);
		longint z, xs, ys;
		z = 0;
		mag = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			z = (y >= 0) ? HALF_TURN : -HALF_TURN;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + longint'(tyae_pkg::atan_lut(i[4:0]));
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - longint'(tyae_pkg::atan_lut(i[4:0]));
			end
		end
		mag = x;
		return z;
	endfunction

	function automatic longint angle_out(longint a, longint lim);
		longint r;
		r = (a + 128) >>> 8;
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

	task automatic predict_item(input sensor_t it);
		longint dx, dy, dz, mag, mag2, roll, pitch, p, y;
		attitude_t res;
		if (!it.op) begin
			sum_x = wrap_bits(sum_x + it.ax, 24);
			sum_y = wrap_bits(sum_y + it.ay, 24);
			sum_z = wrap_bits(sum_z + it.az, 24);
			sum_g = wrap_bits(sum_g + it.gz, 24);
			cal_cnt = (cal_cnt + 1) & 9'h1ff;
			if (cal_cnt >= CAL_N) begin
				off_x = round_mean(sum_x);
				off_y = round_mean(sum_y);
				off_z = round_mean(sum_z) - gravity_reg;
				off_g = wrap_bits(round_mean(sum_g), 16);
				sum_x = 0;
				sum_y = 0;
				sum_z = 0;
				sum_g = 0;
				cal_cnt = 0;
			end
			return;
		end
		dx = it.ax - off_x;
		dy = it.ay - off_y;
		dz = it.az - off_z;
		roll = vector_angle(dz * 16384, dy * 16384, mag);
		mag = (mag * 39797) >>> 16;
		pitch = vector_angle(mag, -dx * 16384, mag2);
		p = (it.gz - off_g) * longint'(it.ms) * gain_reg;
		y = yaw_q16 + ((p + 32768) >>> 16);
		if (y > HALF_TURN)
			y = y - FULL_TURN;
		else if (y < -HALF_TURN)
			y = y + FULL_TURN;
		if (y > HALF_TURN)
			y = HALF_TURN;
		if (y < -HALF_TURN)
			y = -HALF_TURN;
		yaw_q16 = y;
		res.roll = 17'(angle_out(roll, 46080));
		res.pitch = 16'(angle_out(pitch, 23040));
		res.yaw = 17'((yaw_q16 + 128) >>> 8);
		attitude_q.push_back(res);
	endtask

	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			in_taken = 1'b1;
			items_in++;
			predict_item('{in_ch.op, in_ch.accel_x, in_ch.accel_y, in_ch.accel_z,
				in_ch.gyro_z, in_ch.elapsed_ms});
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_out++;
			if (attitude_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: roll %0d pitch %0d yaw %0d",
						out_ch.roll_angle, out_ch.pitch_angle, out_ch.yaw_angle);
			end else begin
				attitude_t e;
				e = attitude_q.pop_front();
				if (e.roll !== out_ch.roll_angle || e.pitch !== out_ch.pitch_angle ||
						e.yaw !== out_ch.yaw_angle) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
							results_out, e.roll, e.pitch, e.yaw, out_ch.roll_angle,
							out_ch.pitch_angle, out_ch.yaw_angle);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!in_ch.valid || in_taken)) begin
			in_taken = 1'b0;
			if (sensor_q.size() > 0 && !((idle_mode == IDLE_SENDER &&
					$urandom_range(99) < 86) || (idle_mode == IDLE_BOTH &&
					$urandom_range(99) < 8))) begin
				drv_item = sensor_q.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.op <= drv_item.op;
				in_ch.accel_x <= drv_item.ax;
				in_ch.accel_y <= drv_item.ay;
				in_ch.accel_z <= drv_item.az;
				in_ch.gyro_z <= drv_item.gz;
				in_ch.elapsed_ms <= drv_item.ms;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_cnt = hold_req;
			hold_req = 0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !((idle_mode == IDLE_RECEIVER && $urandom_range(99) < 86) ||
				(idle_mode == IDLE_BOTH && $urandom_range(99) < 8));
		end
	end

	task automatic add_item(input logic op, input int ax, input int ay, input int az,
			input int gz, input int ms);
		sensor_q.push_back('{op, 16'(ax), 16'(ay), 16'(az), 16'(gz), 16'(ms)});
	endtask

	function automatic int field_value();
		case ($urandom_range(7))
			0: return 32767;
			1: return -32768;
			2: return $urandom_range(200) - 100;
			default: return int'($urandom_range(65535)) - 32768;
		endcase
	endfunction

	task automatic add_cal_block();
		int bx, by, bz, bg, spread;
		bx = field_value();
		by = field_value();
		bz = field_value();
		bg = field_value();
		spread = ($urandom_range(3) == 0) ? 65535 : 64;
		for (int i = 0; i < CAL_N; i++)
			add_item(1'b0, bx + $urandom_range(spread) - spread / 2,
				by + $urandom_range(spread) - spread / 2,
				bz + $urandom_range(spread) - spread / 2,
				bg + $urandom_range(spread) - spread / 2, $urandom_range(65535));
		cal_blocks++;
	endtask

	task automatic add_attitude_run(input int n);
		for (int i = 0; i < n; i++)
			add_item(($urandom_range(9) == 0) ? 1'($urandom_range(1)) : 1'b1,
				field_value(), field_value(), field_value(), field_value(),
				($urandom_range(5) == 0) ? 65535 : $urandom_range(($urandom_range(1)) ?
				65535 : 50));
	endtask

	task automatic drain();
		while (sensor_q.size() > 0 || in_ch.valid || attitude_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [19:0] data);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		if (idx == tyae_pkg::REG_GRAVITY)
			gravity_reg = data & 20'h7fff;
		else if (idx == tyae_pkg::REG_GYRO_GAIN)
			gain_reg = data;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	initial begin
		#6ms;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.op = 1'b0;
		in_ch.accel_x = '0;
		in_ch.accel_y = '0;
		in_ch.accel_z = '0;
		in_ch.gyro_z = '0;
		in_ch.elapsed_ms = '0;
		out_ch.ready = 1'b0;
		idle_mode = IDLE_NONE;
		in_taken = 1'b0;
		hold_req = 0;
		hold_cnt = 0;
		gravity_reg = 4096;
		gain_reg = 65572;
		{sum_x, sum_y, sum_z, sum_g, off_x, off_y, off_z, off_g, yaw_q16} = '0;
		cal_cnt = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items at reset settings: zero vector, negative z on both
		// sides of the y axis, field extremes and an attitude item in the
		// middle of a calibration block.
		add_item(1'b1, 0, 0, 0, 0, 0);
		add_item(1'b1, 0, 500, -1000, 10, 10);
		add_item(1'b1, 0, -500, -1000, -10, 10);
		add_item(1'b1, 0, 0, -1000, 0, 1);
		add_item(1'b1, 32767, 32767, 32767, 32767, 65535);
		add_item(1'b1, -32768, -32768, -32768, -32768, 65535);
		add_item(1'b1, -32768, 32767, 0, 0, 0);
		add_item(1'b1, 32767, 0, 0, 1, 1);
		for (int i = 0; i < CAL_N / 2; i++)
			add_item(1'b0, 30, -20, 4100, 5, 0);
		add_item(1'b1, 100, 100, 100, 100, 100);
		for (int i = 0; i < CAL_N / 2; i++)
			add_item(1'b0, 30, -20, 4100, 5, 0);
		add_item(1'b1, 30, -20, 4100, 5, 20);
		cal_blocks++;
		drain();

		// Largest gain and gravity: single-wrap yaw and its saturation.
		write_reg(tyae_pkg::REG_GRAVITY, 20'd32767);
		write_reg(tyae_pkg::REG_GYRO_GAIN, 20'hfffff);
		write_reg(2'd2, 20'h12345);
		write_reg(2'd3, 20'hfffff);
		add_item(1'b1, 0, 0, 0, 32767, 65535);
		add_item(1'b1, 0, 0, 0, 32767, 65535);
		add_item(1'b1, 0, 0, 0, -32768, 65535);
		add_item(1'b1, 0, 0, 0, -32768, 65535);
		add_item(1'b1, 1, 2, 3, 7, 300);
		drain();

		// Random phases, one idling style each.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_mode = IDLE_SENDER;
					write_reg(tyae_pkg::REG_GRAVITY, 20'd0);
					write_reg(tyae_pkg::REG_GYRO_GAIN, 20'd0);
				end
				1: begin
					idle_mode = IDLE_RECEIVER;
					write_reg(tyae_pkg::REG_GRAVITY, 20'd32767);
					write_reg(tyae_pkg::REG_GYRO_GAIN, 20'hfffff);
				end
				2: begin
					idle_mode = IDLE_BOTH;
					write_reg(tyae_pkg::REG_GRAVITY, 20'($urandom_range(32767)));
					write_reg(tyae_pkg::REG_GYRO_GAIN, 20'($urandom_range(1048575)));
				end
				default: begin
					idle_mode = IDLE_NONE;
					write_reg(tyae_pkg::REG_GRAVITY, 20'd4096);
					write_reg(tyae_pkg::REG_GYRO_GAIN, 20'd65572);
				end
			endcase
			add_attitude_run(20);
			add_cal_block();
			if (ph == 2)
				drain();
			if (ph == 3) begin
				@(posedge clk);
				hold_req = 400;
			end
			add_attitude_run(50);
			drain();
		end

		$display("Ran %0d sensor items (%0d calibration blocks) and checked %0d results",
			items_in, cal_blocks, results_out);
		$display("under four register settings and four idling styles.");
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### filelist.f
rtl/tyae_pkg.sv
rtl/tyae_in_if.sv
rtl/tyae_out_if.sv
rtl/tilt_and_yaw_attitude_estimator.sv
tb/tilt_and_yaw_attitude_estimator_tb.sv
